// File: rtl/value_bit_width_histogram_defines.svh
// ---------------------------------------------------------------------------
// Assertion macros for the value bit width histogram
// Shared property forms; clock and reset are taken from the enclosing module.
// ---------------------------------------------------------------------------
`ifndef VALUE_BIT_WIDTH_HISTOGRAM_DEFINES_SVH
`define VALUE_BIT_WIDTH_HISTOGRAM_DEFINES_SVH

// same-cycle implication
`define VBWH_ASSERT_IMPLY(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define VBWH_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: rtl/vbwh_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// vbwh_pkg
// Types, codes and sizes shared by the histogram controller and datapath.
// ---------------------------------------------------------------------------
package vbwh_pkg;

   localparam int CLASSES    = 16;
   localparam int VALUE_BITS = 32;
   localparam int BINS       = VALUE_BITS + 1;
   localparam int DEPTH      = CLASSES * BINS;
   localparam int ADDR_BITS  = $clog2(DEPTH);
   localparam int COUNT_BITS = 64;
   localparam int WIDTH_BITS = 6;

   localparam logic [1:0] ACT_WRITEBACK = 2'd0;
   localparam logic [1:0] ACT_COMPARE   = 2'd1;
   localparam logic [1:0] ACT_STORE     = 2'd2;
   localparam logic [1:0] ACT_READ      = 2'd3;

   localparam logic [1:0] CMP_SUB = 2'd0;
   localparam logic [1:0] CMP_ADD = 2'd1;
   localparam logic [1:0] CMP_AND = 2'd2;
   localparam logic [1:0] CMP_XOR = 2'd3;

   typedef struct packed {
      logic [1:0]  action;
      logic [3:0]  row;
      logic [31:0] operand_a;
      logic [31:0] operand_b;
      logic [1:0]  compare_kind;
      logic [2:0]  store_bytes;
      logic [5:0]  bin;
   } req_word_type;

   typedef struct packed {
      logic [5:0]  measured_width;
      logic [63:0] bin_count;
   } rsp_word_type;

   typedef enum logic [2:0] {
      ST_CLEAR   = 3'd0,
      ST_IDLE    = 3'd1,
      ST_COMBINE = 3'd2,
      ST_MEASURE = 3'd3,
      ST_ISSUE   = 3'd4,
      ST_UPDATE  = 3'd5
   } state_type;

   typedef struct packed {
      logic clear_en;
      logic capture;
      logic combine;
      logic measure;
      logic issue;
      logic update;
   } ctrl_cmd_type;

   typedef struct packed {
      logic clear_last;
   } dp_status_type;

endpackage

// File: rtl/vbwh_ram.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// vbwh_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ---------------------------------------------------------------------------
module vbwh_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 528
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata_ff
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

endmodule

// File: rtl/vbwh_ctrl.sv
`timescale 1ns / 1ps
`include "value_bit_width_histogram_defines.svh"
// ---------------------------------------------------------------------------
// vbwh_ctrl
// Sequencer: clear pass, then one word through combine, measure, lookup, update.
// ---------------------------------------------------------------------------
module vbwh_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   input  vbwh_pkg::dp_status_type status,
   output vbwh_pkg::ctrl_cmd_type  cmd
);
   import vbwh_pkg::*;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_busy;

   // output register still holds a word nobody has taken
   assign out_busy = rsp_valid_ff && !rsp_ready;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR:   if (status.clear_last) state_in = ST_IDLE;
         ST_IDLE:    if (req_valid) state_in = ST_COMBINE;
         ST_COMBINE: state_in = ST_MEASURE;
         ST_MEASURE: state_in = ST_ISSUE;
         ST_ISSUE:   state_in = ST_UPDATE;
         ST_UPDATE:  if (!out_busy) state_in = ST_IDLE;
         default:    state_in = ST_CLEAR;
      endcase
   end

   always_comb begin
      cmd          = '0;
      req_ready    = 1'b0;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      case (state_ff)
         ST_CLEAR: begin
            cmd.clear_en = 1'b1;
         end
         ST_IDLE: begin
            req_ready   = 1'b1;
            cmd.capture = req_valid;
         end
         ST_COMBINE: cmd.combine = 1'b1;
         ST_MEASURE: cmd.measure = 1'b1;
         ST_ISSUE:   cmd.issue   = 1'b1;
         ST_UPDATE: begin
            if (!out_busy) begin
               cmd.update   = 1'b1;
               rsp_valid_in = 1'b1;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

   `VBWH_ASSERT_NEXT(a_accept_starts, req_valid && req_ready, state_ff == ST_COMBINE, "accept did not start a word")
   `VBWH_ASSERT_NEXT(a_update_loads, state_ff == ST_UPDATE && !out_busy, state_ff == ST_IDLE && rsp_valid_ff, "update did not present a result")

endmodule

// File: rtl/vbwh_datapath.sv
`timescale 1ns / 1ps
`include "value_bit_width_histogram_defines.svh"
// ---------------------------------------------------------------------------
// vbwh_datapath
// Operand combine, width measure, counter read-modify-write and result hold.
// ---------------------------------------------------------------------------
module vbwh_datapath (
   input  logic                   clock,
   input  logic                   reset,
   input  vbwh_pkg::ctrl_cmd_type  cmd,
   output vbwh_pkg::dp_status_type status,
   input  vbwh_pkg::req_word_type  req_word,
   output vbwh_pkg::rsp_word_type  rsp_word
);
   import vbwh_pkg::*;

   req_word_type                item_ff;
   logic [VALUE_BITS-1:0]       value_ff, value_in;
   logic                        signed_ff;
   logic [WIDTH_BITS-1:0]       width_ff, width_in;
   logic [ADDR_BITS-1:0]        addr_ff, addr_in;
   logic                        hit_ff, hit_in;
   logic [ADDR_BITS-1:0]        clear_cnt_ff;
   rsp_word_type                rsp_ff;
   logic [VALUE_BITS-1:0]       mag;
   logic [WIDTH_BITS-1:0]       sel_bin;
   logic                        is_read;
   logic                        row_ok;
   logic                        ram_we;
   logic [ADDR_BITS-1:0]        ram_waddr;
   logic [COUNT_BITS-1:0]       ram_wdata;
   logic [COUNT_BITS-1:0]       ram_rdata;
   logic [COUNT_BITS-1:0]       count_inc;

   assign is_read = (item_ff.action == ACT_READ);
   assign row_ok  = int'(item_ff.row) < CLASSES;

   // combine operands or mask the store payload
   always_comb begin
      value_in = item_ff.operand_a;
      case (item_ff.action)
         ACT_COMPARE: begin
            case (item_ff.compare_kind)
               CMP_SUB: value_in = item_ff.operand_a - item_ff.operand_b;
               CMP_ADD: value_in = item_ff.operand_a + item_ff.operand_b;
               CMP_AND: value_in = item_ff.operand_a & item_ff.operand_b;
               default: value_in = item_ff.operand_a ^ item_ff.operand_b;
            endcase
         end
         ACT_STORE: begin
            case (item_ff.store_bytes)
               3'd0:    value_in = '0;
               3'd1:    value_in = item_ff.operand_a & 32'h0000_00FF;
               3'd2:    value_in = item_ff.operand_a & 32'h0000_FFFF;
               3'd3:    value_in = item_ff.operand_a & 32'h00FF_FFFF;
               default: value_in = item_ff.operand_a;
            endcase
         end
         default: value_in = item_ff.operand_a;
      endcase
   end

   // magnitude, then bit length
   always_comb begin
      mag = value_ff;
      if (signed_ff && value_ff[VALUE_BITS-1]) begin
         mag = ~value_ff + VALUE_BITS'(1);
      end
      width_in = '0;
      for (int i = 0; i < VALUE_BITS; i++) begin
         if (mag[i]) width_in = WIDTH_BITS'(i + 1);
      end
   end

   // counter address: row-major, one row of BINS counters per class
   assign sel_bin = is_read ? item_ff.bin : width_ff;
   always_comb begin
      hit_in  = row_ok && (int'(sel_bin) < BINS);
      addr_in = ADDR_BITS'(int'(item_ff.row) * BINS + int'(sel_bin));
   end

   assign count_inc = ram_rdata + COUNT_BITS'(1);

   always_comb begin
      ram_we    = 1'b0;
      ram_waddr = addr_ff;
      ram_wdata = count_inc;
      if (cmd.clear_en) begin
         ram_we    = 1'b1;
         ram_waddr = clear_cnt_ff;
         ram_wdata = '0;
      end else if (cmd.update && !is_read && hit_ff) begin
         ram_we = 1'b1;
      end
   end

   vbwh_ram #(
      .WIDTH (COUNT_BITS),
      .DEPTH (DEPTH)
   ) u_counts (
      .clock    (clock),
      .we       (ram_we),
      .waddr    (ram_waddr),
      .wdata    (ram_wdata),
      .raddr    (addr_in),
      .rdata_ff (ram_rdata)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         clear_cnt_ff <= '0;
      end else if (cmd.clear_en) begin
         clear_cnt_ff <= clear_cnt_ff + ADDR_BITS'(1);
      end
   end

   assign status.clear_last = (int'(clear_cnt_ff) == DEPTH - 1);

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         item_ff <= req_word;
      end
      if (cmd.combine) begin
         value_ff  <= value_in;
         signed_ff <= (item_ff.action != ACT_STORE);
      end
      if (cmd.measure) begin
         width_ff <= width_in;
      end
      if (cmd.issue) begin
         addr_ff <= addr_in;
         hit_ff  <= hit_in;
      end
      if (cmd.update) begin
         rsp_ff.measured_width <= is_read ? '0 : width_ff;
         if (!hit_ff) begin
            rsp_ff.bin_count <= '0;
         end else if (is_read) begin
            rsp_ff.bin_count <= ram_rdata;
         end else begin
            rsp_ff.bin_count <= count_inc;
         end
      end
   end

   assign rsp_word = rsp_ff;

   `VBWH_ASSERT_IMPLY(a_no_write_on_read, ram_we && !cmd.clear_en, !is_read && hit_ff, "counter written by a read or a miss")

endmodule

// File: rtl/value_bit_width_histogram.sv
// Result: an accepted word steps through combine, measure, lookup and update; the
//   result is registered in update, which waits while the last result is untaken.
// Flow: a single word at a time steps through the read-modify-write, then idle.
// Reset: synchronous; a clearing pass zeroes all 528 counters, one per cycle,
//   and req_ready stays low until the pass is done.
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// value_bit_width_histogram
// Profiles 32-bit values by effective bit width, one histogram row per
// instruction class, with 64-bit wrapping counters in a RAM.
// ---------------------------------------------------------------------------
module value_bit_width_histogram (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  vbwh_pkg::req_word_type req_word,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output vbwh_pkg::rsp_word_type rsp_word
);
   import vbwh_pkg::*;

   ctrl_cmd_type  cmd;
   dp_status_type status;

   // sequencer: owns the handshakes and the step order
   vbwh_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .status    (status),
      .cmd       (cmd)
   );

   // datapath: holds the word, measures it, and updates the counter RAM;
   // the result register keeps the last result until it is taken
   vbwh_datapath u_datapath (
      .clock    (clock),
      .reset    (reset),
      .cmd      (cmd),
      .status   (status),
      .req_word (req_word),
      .rsp_word (rsp_word)
   );

endmodule
